[rtl/core/cpf_pkg.sv]
// Types, codes and helper functions shared by the command packet framer.
package cpf_pkg;

  localparam int S_TDATA_W = 56;
  localparam int QDEPTH = 2;
  localparam int JOB_BYTES = 6;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  localparam logic [7:0] HDR_BASE = 8'h40;
  localparam logic [7:0] HDR_USER = 8'h10;
  localparam logic [7:0] ADDR_MUTE = 8'h40;
  localparam logic [7:0] ADDR_PROTO = 8'h80;
  localparam logic [7:0] SUM_INIT = 8'hFF;
  localparam logic [9:0] MOD_VAL = 10'd255;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BCAST = 2'd1,
    ST_STRAY = 2'd2,
    ST_OPEN  = 2'd3
  } cpf_status_t;

  typedef struct packed {
    logic        func;
    logic [10:0] payload_length;
    logic [7:0]  token;
    logic [4:0]  device_address;
    logic        mute_response;
    logic        user_command;
    logic [15:0] protocol_id;
    logic [7:0]  data_byte;
  } cpf_item_t;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      summed;
    logic                      checks;
    cpf_status_t               status;
  } cpf_job_t;

  function automatic logic [7:0] mod255(input logic [9:0] v);
    logic [9:0] r;
    if (v >= (MOD_VAL << 1)) begin
      r = v - (MOD_VAL << 1);
    end else if (v >= MOD_VAL) begin
      r = v - MOD_VAL;
    end else begin
      r = v;
    end
    return r[7:0];
  endfunction

endpackage

[rtl/core/cpf_front.sv]
// Front end: accepts requests, tracks packet, chunk and group state, and builds jobs.
module cpf_front #(
  parameter int CHUNK_BYTES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  cpf_pkg::cpf_item_t item,
  input  logic               queue_full,
  output logic               job_push,
  output cpf_pkg::cpf_job_t  job
);

  localparam int CW = $clog2(CHUNK_BYTES + 1);

  logic           packet_open, packet_open_next;
  logic [10:0]    bytes_left, bytes_left_next;
  logic [CW-1:0]  chunk_fill, chunk_fill_next;
  logic [1:0]     group_fill, group_fill_next;
  logic [7:0]     group_store [4];
  logic [7:0]     group_store_next [4];
  logic           job_valid;
  logic           accept;
  logic [2:0]     gf_new;
  logic [CW-1:0]  cf_new;
  logic [10:0]    bl_new;
  logic           chunk_end;

  assign item_ready = !queue_full;
  assign accept = item_valid && item_ready;
  assign job_push = accept && job_valid;

  always_comb begin
    packet_open_next = packet_open;
    bytes_left_next = bytes_left;
    chunk_fill_next = chunk_fill;
    group_fill_next = group_fill;
    group_store_next = group_store;
    job = '0;
    job.status = cpf_pkg::ST_OK;
    job_valid = 1'b0;
    gf_new = {1'b0, group_fill} + 3'd1;
    cf_new = chunk_fill + CW'(1);
    bl_new = bytes_left - 11'd1;
    chunk_end = (cf_new >= CW'(CHUNK_BYTES)) || (bl_new == 11'd0);
    case (item.func)
      cpf_pkg::FUNC_START: begin
        job_valid = 1'b1;
        if (packet_open) begin
          job.count = 3'd1;
          job.status = cpf_pkg::ST_OPEN;
        end else if (item.device_address == 5'd0 && !item.mute_response) begin
          job.count = 3'd1;
          job.status = cpf_pkg::ST_BCAST;
        end else begin
          job.bytes[0] = cpf_pkg::HDR_BASE | {5'd0, item.payload_length[10:8]} |
                         (item.user_command ? cpf_pkg::HDR_USER : 8'd0);
          job.bytes[1] = item.payload_length[7:0];
          job.bytes[2] = item.token;
          job.bytes[3] = {3'd0, item.device_address} |
                         (item.mute_response ? cpf_pkg::ADDR_MUTE : 8'd0) |
                         ((item.protocol_id != 16'd0) ? cpf_pkg::ADDR_PROTO : 8'd0);
          job.bytes[4] = item.protocol_id[15:8];
          job.bytes[5] = item.protocol_id[7:0];
          job.count = (item.protocol_id != 16'd0) ? 3'd6 : 3'd4;
          job.summed = 1'b1;
          job.checks = 1'b1;
          bytes_left_next = item.payload_length;
          packet_open_next = (item.payload_length != 11'd0);
          chunk_fill_next = '0;
          group_fill_next = 2'd0;
        end
      end
      default: begin
        if (!packet_open) begin
          job_valid = 1'b1;
          job.count = 3'd1;
          job.status = cpf_pkg::ST_STRAY;
        end else begin
          group_store_next[group_fill] = item.data_byte;
          bytes_left_next = bl_new;
          if (gf_new == 3'd4 || chunk_end) begin
            job_valid = 1'b1;
            for (int k = 0; k < 4; k++) begin
              job.bytes[k] = group_store_next[2'(gf_new - 3'd1 - 3'(k))];
            end
            job.count = gf_new;
            job.summed = 1'b1;
            job.checks = chunk_end;
            group_fill_next = 2'd0;
          end else begin
            group_fill_next = gf_new[1:0];
          end
          chunk_fill_next = chunk_end ? '0 : cf_new;
          if (bl_new == 11'd0) begin
            packet_open_next = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      bytes_left <= '0;
      chunk_fill <= '0;
      group_fill <= '0;
      for (int k = 0; k < 4; k++) begin
        group_store[k] <= '0;
      end
    end else if (accept) begin
      packet_open <= packet_open_next;
      bytes_left <= bytes_left_next;
      chunk_fill <= chunk_fill_next;
      group_fill <= group_fill_next;
      group_store <= group_store_next;
    end
  end

endmodule

[rtl/core/cpf_queue.sv]
// Short job queue that decouples the front end from the byte emitter.
module cpf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cpf_pkg::cpf_job_t push_job,
  input  logic              pop,
  output cpf_pkg::cpf_job_t head_job,
  output logic              empty,
  output logic              full
);

  localparam int PW = (cpf_pkg::QDEPTH > 1) ? $clog2(cpf_pkg::QDEPTH) : 1;
  localparam int CNTW = $clog2(cpf_pkg::QDEPTH + 1);

  cpf_pkg::cpf_job_t entries [cpf_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign empty = (count == '0);
  assign full = (count == CNTW'(cpf_pkg::QDEPTH));
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == PW'(cpf_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(cpf_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

[rtl/core/cpf_back.sv]
// Back end: emits job bytes one per cycle unless stalled, with running Fletcher-16 sums and check bytes.
module cpf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  cpf_pkg::cpf_job_t job,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic [1:0]        out_status
);

  typedef enum logic [1:0] {
    PH_BYTES,
    PH_CHK0,
    PH_CHK1
  } phase_t;

  phase_t     phase;
  logic [2:0] idx;
  logic [7:0] sum_low;
  logic [7:0] sum_high;
  logic [7:0] c0;
  logic       advance;
  logic       step;
  logic       at_end;
  logic [7:0] cur_byte;
  logic [7:0] sl_add;
  logic [7:0] sh_add;
  logic [7:0] c0_calc;
  logic [7:0] c1_calc;

  assign advance = !out_valid || out_ready;
  assign step = advance && job_valid;
  assign at_end = (idx == job.count - 3'd1);
  assign cur_byte = job.bytes[idx];
  assign sl_add = cpf_pkg::mod255({2'b00, sum_low} + {2'b00, cur_byte});
  assign sh_add = cpf_pkg::mod255({2'b00, sum_high} + {2'b00, sl_add});
  assign c0_calc = cpf_pkg::SUM_INIT - cpf_pkg::mod255({2'b00, sum_low} + {2'b00, sum_high});
  assign c1_calc = cpf_pkg::SUM_INIT - cpf_pkg::mod255({2'b00, sum_low} + {2'b00, c0});

  always_comb begin
    job_pop = 1'b0;
    if (step) begin
      case (phase)
        PH_BYTES: job_pop = at_end && !job.checks;
        PH_CHK1:  job_pop = 1'b1;
        default:  job_pop = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BYTES;
      idx <= '0;
      sum_low <= cpf_pkg::SUM_INIT;
      sum_high <= cpf_pkg::SUM_INIT;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= job_valid;
      if (job_valid) begin
        case (phase)
          PH_BYTES: begin
            out_byte <= cur_byte;
            out_status <= 2'(job.status);
            out_last <= at_end && !job.checks;
            if (job.summed) begin
              sum_low <= sl_add;
              sum_high <= sh_add;
            end
            if (at_end) begin
              idx <= '0;
              if (job.checks) begin
                phase <= PH_CHK0;
              end
            end else begin
              idx <= idx + 3'd1;
            end
          end
          PH_CHK0: begin
            out_byte <= c0_calc;
            out_status <= 2'(cpf_pkg::ST_OK);
            out_last <= 1'b0;
            c0 <= c0_calc;
            phase <= PH_CHK1;
          end
          default: begin
            out_byte <= c1_calc;
            out_status <= 2'(cpf_pkg::ST_OK);
            out_last <= 1'b1;
            sum_low <= cpf_pkg::SUM_INIT;
            sum_high <= cpf_pkg::SUM_INIT;
            phase <= PH_BYTES;
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/command_packet_framer_fletcher16_unit.sv]
// Top level of the command packet framer with Fletcher-16 check bytes.
// A request on the input stream is taken whenever the two-entry job queue has room, and the
// front end classifies it at once; the back end then sends one framed byte per cycle while
// the output is taken. A start request yields 6 or 8 bytes (header plus two check bytes),
// a payload request that completes a group of four, a chunk of CHUNK_BYTES or the packet
// yields that group's bytes, plus 2 check bytes at the end of each chunk or packet, a
// payload request that leaves a group incomplete yields none, and an error yields one byte
// with tlast set and the status on tuser. The sustained rate is set by the back end's single
// output byte per cycle.
module command_packet_framer_fletcher16_unit #(
  parameter int CHUNK_BYTES = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // payload_length, token, device_address, mute_response, user_command, protocol_id,
  // data_byte, zero fill
  input  logic [cpf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // func
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_byte
  output logic [7:0]                    m_axis_tdata,
  output logic                          m_axis_tlast,
  // status
  output logic [1:0]                    m_axis_tuser
);

  cpf_pkg::cpf_item_t item;
  cpf_pkg::cpf_job_t  push_job;
  cpf_pkg::cpf_job_t  head_job;
  logic               job_push;
  logic               job_pop;
  logic               q_empty;
  logic               q_full;

  assign item.func = s_axis_tuser;
  assign item.payload_length = s_axis_tdata[10:0];
  assign item.token = s_axis_tdata[18:11];
  assign item.device_address = s_axis_tdata[23:19];
  assign item.mute_response = s_axis_tdata[24];
  assign item.user_command = s_axis_tdata[25];
  assign item.protocol_id = s_axis_tdata[41:26];
  assign item.data_byte = s_axis_tdata[49:42];

  cpf_front #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_axis_tvalid),
    .item_ready (s_axis_tready),
    .item       (item),
    .queue_full (q_full),
    .job_push   (job_push),
    .job        (push_job)
  );

  cpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  cpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (!q_empty),
    .job        (head_job),
    .job_pop    (job_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_status (m_axis_tuser)
  );

endmodule

[rtl/core/cpf_checker.sv]
// Port-level checker for the command packet framer, bound to the top level.
module cpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != 2'(cpf_pkg::ST_OK))
      |-> (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("error result is not a single zero byte with tlast");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready)
      |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
           $stable(m_axis_tuser)))
    else $error("stalled output request changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output request right after reset");

endmodule

bind command_packet_framer_fletcher16_unit cpf_checker u_checker (.*);

[bench/command_packet_framer_fletcher16_unit_tb.sv]
// Self-checking testbench for the command packet framer with Fletcher-16 check bytes.
module command_packet_framer_fletcher16_unit_tb;
  import cpf_pkg::*;

  localparam int CHUNK = 128;

  typedef struct {
    cpf_item_t req;
    bit        wait_idle;
  } pending_req_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    cpf_status_t status;
  } frame_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tlast;
  logic [1:0]           m_axis_tuser;

  pending_req_t pending_reqs[$];
  frame_byte_t  expected_bytes[$];
  frame_byte_t  burst[$];
  pending_req_t head_req;
  frame_byte_t  want_byte;
  int           sent_count = 0;
  int           mismatches = 0;
  logic         rx_hold = 1'b0;
  logic         hold_used = 1'b0;
  int           hold_left = 0;
  logic         keep_offer;
  logic         steady;

  logic        pkt_open = 1'b0;
  logic [10:0] bytes_remaining = '0;
  int          chunk_count = 0;
  logic [7:0]  group_bytes[4] = '{default: 8'h00};
  logic [2:0]  group_count = '0;
  logic [7:0]  sum_lo = SUM_INIT;
  logic [7:0]  sum_hi = SUM_INIT;

  command_packet_framer_fletcher16_unit #(.CHUNK_BYTES(CHUNK)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  assign steady = (sent_count >= 250) && (sent_count < 330);

  function automatic logic [S_TDATA_W-1:0] pack_request(input cpf_item_t r);
    return {6'd0, r.data_byte, r.protocol_id, r.user_command, r.mute_response,
            r.device_address, r.token, r.payload_length};
  endfunction

  function automatic void add_byte(input logic [7:0] d, input cpf_status_t st);
    frame_byte_t fb;
    fb.data = d;
    fb.last = 1'b0;
    fb.status = st;
    burst.insert(burst.size(), fb);
  endfunction

  function automatic void add_summed(input logic [7:0] b);
    sum_lo = 8'((int'(sum_lo) + int'(b)) % 255);
    sum_hi = 8'((int'(sum_hi) + int'(sum_lo)) % 255);
    add_byte(b, ST_OK);
  endfunction

  function automatic void add_checks();
    int c0;
    int c1;
    c0 = 255 - ((int'(sum_lo) + int'(sum_hi)) % 255);
    c1 = 255 - ((int'(sum_lo) + c0) % 255);
    add_byte(8'(c0), ST_OK);
    add_byte(8'(c1), ST_OK);
    sum_lo = SUM_INIT;
    sum_hi = SUM_INIT;
  endfunction

  function automatic void frame_request(input cpf_item_t r);
    logic [7:0] h0;
    logic [7:0] h3;
    bit         chunk_end;
    int         i;
    burst.delete();
    if (r.func == FUNC_START) begin
      if (pkt_open) begin
        add_byte(8'h00, ST_OPEN);
      end else if (r.device_address == 5'd0 && !r.mute_response) begin
        add_byte(8'h00, ST_BCAST);
      end else begin
        sum_lo = SUM_INIT;
        sum_hi = SUM_INIT;
        h0 = HDR_BASE | {5'd0, r.payload_length[10:8]};
        if (r.user_command) h0 = h0 | HDR_USER;
        h3 = {3'd0, r.device_address};
        if (r.mute_response) h3 = h3 | ADDR_MUTE;
        if (r.protocol_id != 16'd0) h3 = h3 | ADDR_PROTO;
        add_summed(h0);
        add_summed(r.payload_length[7:0]);
        add_summed(r.token);
        add_summed(h3);
        if (r.protocol_id != 16'd0) begin
          add_summed(r.protocol_id[15:8]);
          add_summed(r.protocol_id[7:0]);
        end
        add_checks();
        bytes_remaining = r.payload_length;
        pkt_open = (r.payload_length != 11'd0);
        chunk_count = 0;
        group_count = '0;
      end
    end else if (!pkt_open) begin
      add_byte(8'h00, ST_STRAY);
    end else begin
      group_bytes[group_count[1:0]] = r.data_byte;
      group_count = group_count + 3'd1;
      chunk_count++;
      bytes_remaining = bytes_remaining - 11'd1;
      chunk_end = (chunk_count >= CHUNK) || (bytes_remaining == 11'd0);
      if (group_count >= 3'd4 || chunk_end) begin
        for (i = (group_count > 3'd4) ? 4 : int'(group_count); i > 0; i--) begin
          add_summed(group_bytes[i-1]);
        end
        group_count = '0;
      end
      if (chunk_end) begin
        add_checks();
        chunk_count = 0;
      end
      if (bytes_remaining == 11'd0) pkt_open = 1'b0;
    end
    if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[k]) expected_bytes.insert(expected_bytes.size(), burst[k]);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Driver: offers the head of the request queue and predicts each accepted request.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      keep_offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        head_req = pending_reqs.pop_front();
        frame_request(head_req.req);
        sent_count <= sent_count + 1;
        keep_offer = 1'b0;
      end
      if (!keep_offer) begin
        if (pending_reqs.size() != 0
            && !(pending_reqs[0].wait_idle && expected_bytes.size() != 0)
            && (steady || rx_hold || $urandom_range(0, 99) >= 32)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pack_request(pending_reqs[0].req);
          s_axis_tuser <= pending_reqs[0].req.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted output byte with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h", m_axis_tdata));
        end else begin
          want_byte = expected_bytes.pop_front();
          if (m_axis_tdata !== want_byte.data)
            report_mismatch($sformatf("byte %h, want %h", m_axis_tdata, want_byte.data));
          if (m_axis_tlast !== want_byte.last)
            report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want_byte.last));
          if (m_axis_tuser !== want_byte.status)
            report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser,
                                      want_byte.status));
        end
      end
      m_axis_tready <= !rx_hold && (steady || $urandom_range(0, 99) >= 32);
    end
  end

  // The output side is held off once for a long stretch so that the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 1'b0;
    end else if (!hold_used && sent_count >= 100) begin
      rx_hold <= 1'b1;
      hold_used <= 1'b1;
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) rx_hold <= 1'b0;
    end
  end

  function automatic cpf_item_t rand_fields();
    cpf_item_t r;
    r.func = 1'($urandom_range(0, 1));
    r.payload_length = 11'($urandom_range(0, 2047));
    r.token = 8'($urandom_range(0, 255));
    r.device_address = 5'($urandom_range(0, 31));
    r.mute_response = 1'($urandom_range(0, 1));
    r.user_command = 1'($urandom_range(0, 1));
    r.protocol_id = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
    r.data_byte = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic queue_req(input cpf_item_t r, input bit wait_idle);
    pending_req_t p;
    p.req = r;
    p.wait_idle = wait_idle;
    pending_reqs.insert(pending_reqs.size(), p);
  endtask

  task automatic queue_fixed(input logic func, input int len, input int token,
                             input int addr, input logic mute, input logic user,
                             input int proto, input int data);
    cpf_item_t r;
    r.func = func;
    r.payload_length = 11'(len);
    r.token = 8'(token);
    r.device_address = 5'(addr);
    r.mute_response = mute;
    r.user_command = user;
    r.protocol_id = 16'(proto);
    r.data_byte = 8'(data);
    queue_req(r, 1'b0);
  endtask

  task automatic queue_packet(input int len, input bit wait_idle);
    cpf_item_t r;
    int k;
    r = rand_fields();
    r.func = FUNC_START;
    r.payload_length = 11'(len);
    if (r.device_address == 5'd0) r.mute_response = 1'b1;
    queue_req(r, wait_idle);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 4) begin
        r = rand_fields();
        r.func = FUNC_START;
        queue_req(r, 1'b0);
      end
      r = rand_fields();
      r.func = FUNC_DATA;
      queue_req(r, 1'b0);
    end
  endtask

  initial begin
    cpf_item_t r;
    int len;
    int pick;

    // Stray byte, unmuted broadcast, empty packet and a start inside an open packet.
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'hA5);
    queue_fixed(FUNC_START, 2047, 8'hFF, 0, 1'b0, 1'b1, 16'hFFFF, 8'hFF);
    queue_fixed(FUNC_START, 0, 8'h00, 0, 1'b1, 1'b1, 0, 0);
    queue_fixed(FUNC_START, 5, 8'hFF, 31, 1'b0, 1'b0, 16'hFFFF, 0);
    queue_fixed(FUNC_START, 7, 8'h3C, 5, 1'b1, 1'b0, 0, 0);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h00);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'hFF);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h12);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h34);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h56);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h0F);
    queue_fixed(FUNC_START, 1, 8'h80, 1, 1'b1, 1'b1, 16'h0001, 0);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h7E);
    queue_fixed(FUNC_START, 3, 8'h01, 16, 1'b0, 1'b1, 16'h8000, 0);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h01);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h02);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'h03);
    queue_fixed(FUNC_START, 4, 8'h55, 2, 1'b1, 1'b0, 0, 0);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'hC1);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'hC2);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'hC3);
    queue_fixed(FUNC_DATA, 0, 0, 0, 1'b0, 1'b0, 0, 8'hC4);

    // A packet at least one chunk long, sent only once the block has gone idle.
    queue_packet($urandom_range(CHUNK, CHUNK + 7), 1'b1);
    while (pending_reqs.size() < 450) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) len = $urandom_range(0, 12);
        else if (pick < 94) len = $urandom_range(13, 40);
        else len = $urandom_range(CHUNK - 8, CHUNK + 12);
        if (len > 460 - pending_reqs.size()) len = 460 - pending_reqs.size();
        queue_packet(len, 1'b0);
      end else begin
        r = rand_fields();
        if (r.func == FUNC_START) begin
          r.device_address = 5'd0;
          r.mute_response = 1'b0;
        end
        queue_req(r, 1'b0);
      end
    end
    // A header with the longest length, again after the block has drained.
    r = rand_fields();
    r.func = FUNC_START;
    r.payload_length = 11'h7FF;
    r.device_address = 5'd31;
    queue_req(r, 1'b1);
    r = rand_fields();
    r.func = FUNC_DATA;
    queue_req(r, 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
